// ===== design/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg: shared types and constants for the cell pool allocator
// Pool geometry, word layouts, action and status codes, control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

	// pool geometry
	localparam int CELLS_PER_BLOCK = 256;
	localparam int NUM_BLOCKS      = 16;
	localparam int POOL_CELLS      = CELLS_PER_BLOCK * NUM_BLOCKS;

	// map is held as rows of ROW_CELLS cells, two bits per cell
	localparam int ROW_CELLS      = 16;
	localparam int ROW_W          = 2 * ROW_CELLS;
	localparam int NUM_ROWS       = POOL_CELLS / ROW_CELLS;
	localparam int ROWS_PER_BLOCK = CELLS_PER_BLOCK / ROW_CELLS;

	localparam int COL_W    = $clog2(ROW_CELLS);
	localparam int ROW_AW   = $clog2(NUM_ROWS);
	localparam int RPB_W    = $clog2(ROWS_PER_BLOCK);
	localparam int BLK_W    = $clog2(NUM_BLOCKS);
	localparam int IDX_W    = 12;
	localparam int CNT_W    = 13;
	localparam int ROVER_W  = $clog2(CELLS_PER_BLOCK) + 1;
	localparam int STACK_AW = $clog2(POOL_CELLS);

	// actions
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_MARK  = 2'd2;
	localparam logic [1:0] ACT_SWEEP = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOFREE   = 3'd1;
	localparam logic [2:0] ST_MARKED   = 3'd2;
	localparam logic [2:0] ST_NOTALLOC = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic [1:0]       action;
		logic [IDX_W-1:0] cell_index;
	} req_word_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [IDX_W-1:0] result_cell;
		logic [CNT_W-1:0] used_cells;
		logic [CNT_W-1:0] freed_cells;
	} rsp_word_t;

	// controller -> datapath
	typedef struct packed {
		logic do_push;
		logic do_pop;
		logic pop_done;
		logic mark_rd;
		logic mark_chk;
		logic scan_init;
		logic sweep_init;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pop_ok;
		logic scan_hit;
		logic scan_fail;
		logic sweep_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/cpa_ram.sv =====
// ----------------------------------------------------------------------------
// cpa_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/cpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpa_ctrl: action sequencer
// Takes one request word at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic [1:0]        action,
	input  wire logic              out_free,
	input  wire cpa_pkg::dp_stat_t stat,
	output logic                   req_stall,
	output logic                   load_out,
	output cpa_pkg::dp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_WAIT,
		S_MARK_CHK,
		S_SCAN,
		S_SWEEP,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd       = '0;
		load_out  = 1'b0;
		req_stall = 1'b1;
		state_d   = state_q;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					unique case (action)
						cpa_pkg::ACT_ALLOC: begin
							if (stat.pop_ok) begin
								cmd.do_pop = 1'b1;
								state_d    = S_POP_WAIT;
							end else begin
								cmd.scan_init = 1'b1;
								state_d       = S_SCAN;
							end
						end
						cpa_pkg::ACT_FREE: begin
							cmd.do_push = 1'b1;
							state_d     = S_RESULT;
						end
						cpa_pkg::ACT_MARK: begin
							cmd.mark_rd = 1'b1;
							state_d     = S_MARK_CHK;
						end
						cpa_pkg::ACT_SWEEP: begin
							cmd.sweep_init = 1'b1;
							state_d        = S_SWEEP;
						end
					endcase
				end
			end
			S_POP_WAIT: begin
				cmd.pop_done = 1'b1;
				state_d      = S_RESULT;
			end
			S_MARK_CHK: begin
				cmd.mark_chk = 1'b1;
				state_d      = S_RESULT;
			end
			S_SCAN: begin
				if (stat.scan_hit || stat.scan_fail) begin
					state_d = S_RESULT;
				end
			end
			S_SWEEP: begin
				if (stat.sweep_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/cpa_dpath.sv =====
// ----------------------------------------------------------------------------
// cpa_dpath: pool datapath
// Cell map RAM with row valid bits, free stack RAM, rover, counters,
// next-fit scan pipeline and sweep pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cpa_pkg::req_word_t req,
	input  wire cpa_pkg::dp_cmd_t   cmd,
	output cpa_pkg::dp_stat_t       stat,
	output cpa_pkg::rsp_word_t      res
);

	localparam int ROW_W    = cpa_pkg::ROW_W;
	localparam int ROW_AW   = cpa_pkg::ROW_AW;
	localparam int COL_W    = cpa_pkg::COL_W;
	localparam int RPB_W    = cpa_pkg::RPB_W;
	localparam int BLK_W    = cpa_pkg::BLK_W;
	localparam int IDX_W    = cpa_pkg::IDX_W;
	localparam int CNT_W    = cpa_pkg::CNT_W;
	localparam int ROVER_W  = cpa_pkg::ROVER_W;
	localparam int STACK_AW = cpa_pkg::STACK_AW;
	localparam int CIB_W    = ROVER_W - 1;

	// architectural state
	logic [CNT_W-1:0]             depth_q;
	logic [BLK_W-1:0]             rover_blk_q;
	logic [ROVER_W-1:0]           rover_cell_q;
	logic [CNT_W-1:0]             used_q;
	logic [cpa_pkg::NUM_ROWS-1:0] rvld_q;

	// result holding
	logic [2:0]       res_status_q;
	logic [IDX_W-1:0] res_cell_q;
	logic [CNT_W-1:0] res_freed_q;
	logic [IDX_W-1:0] idx_q;

	// scan issue and check
	logic              iss_on_q;
	logic              ph_q;
	logic              first_q;
	logic [ROW_AW-1:0] cnt_q;
	logic              scv_s1;
	logic              first_s1;

	// sweep issue and check
	logic              sw_on_q;
	logic [ROW_AW-1:0] sw_cnt_q;
	logic              sv_s1;
	logic [CNT_W-1:0]  used_acc_q;
	logic [CNT_W-1:0]  freed_acc_q;

	// shared check stage
	logic [ROW_AW-1:0] row_s1;
	logic              last_s1;
	logic              rdv_s1;

	// memories
	logic              map_we;
	logic [ROW_AW-1:0] map_waddr;
	logic [ROW_W-1:0]  map_wdata;
	logic [ROW_AW-1:0] map_raddr;
	logic [ROW_W-1:0]  map_rdata;
	logic [ROW_W-1:0]  row_data;

	logic                stk_we;
	logic [STACK_AW-1:0] stk_raddr;
	logic [IDX_W-1:0]    stk_rdata;

	// combinational terms
	logic              req_oob;
	logic              push_ok;
	logic [ROW_AW-1:0] issue_row;
	logic              issuing;
	logic [cpa_pkg::ROW_CELLS-1:0] free_v;
	logic              row_hit;
	logic [COL_W-1:0]  hit_j;
	logic              scan_hit;
	logic              scan_fail;
	logic              idx_oob;
	logic [1:0]        mk_bits;
	logic              mark_wr;
	logic [ROW_W-1:0]  sweep_row;
	logic [cpa_pkg::ROW_CELLS-1:0] mk_v;
	logic [cpa_pkg::ROW_CELLS-1:0] fr_v;
	logic [CNT_W-1:0]  used_row;
	logic [CNT_W-1:0]  freed_row;
	logic              sweep_done;

	cpa_ram #(
		.WIDTH (ROW_W),
		.DEPTH (cpa_pkg::NUM_ROWS)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	cpa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (cpa_pkg::POOL_CELLS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[STACK_AW-1:0]),
		.wdata (req.cell_index),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// free stack
	assign req_oob   = CNT_W'(req.cell_index) >= CNT_W'(cpa_pkg::POOL_CELLS);
	assign push_ok   = !req_oob && (depth_q < CNT_W'(cpa_pkg::POOL_CELLS));
	assign stk_we    = cmd.do_push && push_ok;
	assign stk_raddr = STACK_AW'(depth_q - CNT_W'(1));

	// unwritten rows read as empty
	assign row_data = map_rdata & {ROW_W{rdv_s1}};

	// scan issue address
	always_comb begin
		if (!ph_q) begin
			issue_row = {rover_blk_q, cnt_q[RPB_W-1:0]};
		end else begin
			issue_row = {rover_blk_q, RPB_W'(0)} + cnt_q;
		end
	end

	// free cells of the row under check, first row masked below the rover
	always_comb begin
		for (int j = 0; j < cpa_pkg::ROW_CELLS; j++) begin
			free_v[j] = (row_data[2*j +: 2] == 2'b00) &&
				(!first_s1 || (COL_W'(j) >= rover_cell_q[COL_W-1:0]));
		end
	end

	always_comb begin
		hit_j = '0;
		for (int j = cpa_pkg::ROW_CELLS - 1; j >= 0; j--) begin
			if (free_v[j]) begin
				hit_j = COL_W'(j);
			end
		end
	end

	assign row_hit   = |free_v;
	assign scan_hit  = scv_s1 && row_hit;
	assign scan_fail = scv_s1 && !row_hit && last_s1;
	assign issuing   = iss_on_q && !scan_hit && !scan_fail;

	// mark check
	assign idx_oob = CNT_W'(idx_q) >= CNT_W'(cpa_pkg::POOL_CELLS);
	assign mk_bits = row_data[{idx_q[COL_W-1:0], 1'b0} +: 2];
	assign mark_wr = cmd.mark_chk && !idx_oob && !mk_bits[1] && mk_bits[0];

	// sweep of one row: marks cleared, unmarked cells released
	always_comb begin
		for (int j = 0; j < cpa_pkg::ROW_CELLS; j++) begin
			sweep_row[2*j +: 2] = {1'b0, row_data[2*j+1] & row_data[2*j]};
			mk_v[j]             = row_data[2*j+1];
			fr_v[j]             = (row_data[2*j +: 2] == 2'b01);
		end
	end

	assign used_row   = CNT_W'($countones(mk_v));
	assign freed_row  = CNT_W'($countones(fr_v));
	assign sweep_done = sv_s1 && last_s1;

	// map ports
	always_comb begin
		map_we    = 1'b0;
		map_waddr = row_s1;
		map_wdata = sweep_row;
		if (scan_hit) begin
			map_we    = 1'b1;
			map_wdata = row_data | (ROW_W'(1) << {hit_j, 1'b0});
		end else if (mark_wr) begin
			map_we    = 1'b1;
			map_waddr = idx_q[IDX_W-1:COL_W];
			map_wdata = row_data | (ROW_W'(2) << {idx_q[COL_W-1:0], 1'b0});
		end else if (sv_s1) begin
			map_we = 1'b1;
		end
	end

	always_comb begin
		if (cmd.mark_rd) begin
			map_raddr = req.cell_index[IDX_W-1:COL_W];
		end else if (sw_on_q) begin
			map_raddr = sw_cnt_q;
		end else begin
			map_raddr = issue_row;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= '0;
			rover_blk_q  <= '0;
			rover_cell_q <= '0;
			used_q       <= '0;
			rvld_q       <= '0;
			iss_on_q     <= 1'b0;
			ph_q         <= 1'b0;
			first_q      <= 1'b0;
			cnt_q        <= '0;
			scv_s1       <= 1'b0;
			sw_on_q      <= 1'b0;
			sw_cnt_q     <= '0;
			sv_s1        <= 1'b0;
		end else begin
			if (map_we) begin
				rvld_q[map_waddr] <= 1'b1;
			end

			if (stk_we) begin
				depth_q <= depth_q + CNT_W'(1);
			end else if (cmd.do_pop) begin
				depth_q <= depth_q - CNT_W'(1);
			end

			// scan sequencing
			if (cmd.scan_init) begin
				iss_on_q <= 1'b1;
				first_q  <= 1'b1;
				if (rover_cell_q == ROVER_W'(cpa_pkg::CELLS_PER_BLOCK)) begin
					ph_q  <= 1'b1;
					cnt_q <= '0;
				end else begin
					ph_q  <= 1'b0;
					cnt_q <= ROW_AW'(rover_cell_q[CIB_W-1:COL_W]);
				end
			end else if (issuing) begin
				first_q <= 1'b0;
				if (!ph_q) begin
					if (cnt_q[RPB_W-1:0] == RPB_W'(cpa_pkg::ROWS_PER_BLOCK - 1)) begin
						ph_q  <= 1'b1;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + ROW_AW'(1);
					end
				end else if (cnt_q == ROW_AW'(cpa_pkg::NUM_ROWS - 1)) begin
					iss_on_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + ROW_AW'(1);
				end
			end else begin
				iss_on_q <= 1'b0;
			end
			scv_s1 <= issuing;

			if (scan_hit) begin
				used_q       <= used_q + CNT_W'(1);
				rover_blk_q  <= row_s1[ROW_AW-1:RPB_W];
				rover_cell_q <= ROVER_W'({row_s1[RPB_W-1:0], hit_j}) + ROVER_W'(1);
			end else if (scan_fail) begin
				rover_cell_q <= '0;
			end

			// sweep sequencing
			if (cmd.sweep_init) begin
				sw_on_q  <= 1'b1;
				sw_cnt_q <= '0;
			end else if (sw_on_q) begin
				sw_cnt_q <= sw_cnt_q + ROW_AW'(1);
				if (sw_cnt_q == ROW_AW'(cpa_pkg::NUM_ROWS - 1)) begin
					sw_on_q <= 1'b0;
				end
			end
			sv_s1 <= sw_on_q;

			if (sweep_done) begin
				used_q <= used_acc_q + used_row;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		rdv_s1 <= rvld_q[map_raddr];
		if (issuing) begin
			row_s1   <= issue_row;
			first_s1 <= first_q && !ph_q;
			last_s1  <= ph_q && (cnt_q == ROW_AW'(cpa_pkg::NUM_ROWS - 1));
		end else if (sw_on_q) begin
			row_s1  <= sw_cnt_q;
			last_s1 <= (sw_cnt_q == ROW_AW'(cpa_pkg::NUM_ROWS - 1));
		end

		if (cmd.sweep_init) begin
			used_acc_q  <= '0;
			freed_acc_q <= '0;
		end else if (sv_s1) begin
			used_acc_q  <= used_acc_q + used_row;
			freed_acc_q <= freed_acc_q + freed_row;
		end

		if (cmd.mark_rd) begin
			idx_q <= req.cell_index;
		end

		if (cmd.do_push) begin
			res_cell_q  <= '0;
			res_freed_q <= '0;
			if (req_oob) begin
				res_status_q <= cpa_pkg::ST_NOTALLOC;
			end else if (!push_ok) begin
				res_status_q <= cpa_pkg::ST_OVERFLOW;
			end else begin
				res_status_q <= cpa_pkg::ST_OK;
			end
		end else if (cmd.pop_done) begin
			res_status_q <= cpa_pkg::ST_OK;
			res_cell_q   <= stk_rdata;
			res_freed_q  <= '0;
		end else if (cmd.mark_chk) begin
			res_cell_q  <= '0;
			res_freed_q <= '0;
			if (idx_oob) begin
				res_status_q <= cpa_pkg::ST_NOTALLOC;
			end else if (mk_bits[1]) begin
				res_status_q <= cpa_pkg::ST_MARKED;
			end else if (!mk_bits[0]) begin
				res_status_q <= cpa_pkg::ST_NOTALLOC;
			end else begin
				res_status_q <= cpa_pkg::ST_OK;
			end
		end else if (scan_hit) begin
			res_status_q <= cpa_pkg::ST_OK;
			res_cell_q   <= IDX_W'({row_s1, hit_j});
			res_freed_q  <= '0;
		end else if (scan_fail) begin
			res_status_q <= cpa_pkg::ST_NOFREE;
			res_cell_q   <= '0;
			res_freed_q  <= '0;
		end else if (sweep_done) begin
			res_status_q <= cpa_pkg::ST_OK;
			res_cell_q   <= '0;
			res_freed_q  <= freed_acc_q + freed_row;
		end
	end

	assign stat.pop_ok     = (depth_q != '0);
	assign stat.scan_hit   = scan_hit;
	assign stat.scan_fail  = scan_fail;
	assign stat.sweep_done = sweep_done;

	assign res.status      = res_status_q;
	assign res.result_cell = res_cell_q;
	assign res.used_cells  = used_q;
	assign res.freed_cells = res_freed_q;

endmodule

`default_nettype wire

// ===== design/cell_pool_alloc_mark_sweep.sv =====
// ----------------------------------------------------------------------------
// cell_pool_alloc_mark_sweep: cell pool allocator with mark and sweep
// Alloc, free, mark and sweep over a 16 x 256 cell pool.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid / req_stall / req): one word per action,
//   alloc, free, mark or sweep, with a flat cell number. Response channel
//   (rsp_valid / rsp_stall / rsp): exactly one word per request, in order.
//   One action is in flight at a time; req_stall is high while it runs.
//   An alloc pops the free stack when it holds a cell, else scans the map
//   row by row, a row being 16 cells, bounded by the single map RAM read
//   port. A sweep reads all NUM_ROWS = 256 map rows, one map row per cycle.
//   The response sits in an output register, so the next request is taken
//   while a finished word waits on rsp_stall; that request then holds its
//   result until the register frees up.
//   Reset clears the map at once through per-row valid bits (no clearing
//   pass), empties the free stack and zeroes rover and use count; the
//   block is idle and takes requests straight out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_pool_alloc_mark_sweep (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire cpa_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output cpa_pkg::rsp_word_t      rsp
);

	cpa_pkg::dp_cmd_t   cmd;
	cpa_pkg::dp_stat_t  stat;
	cpa_pkg::rsp_word_t res;
	logic               load_out;
	logic               out_free;
	logic               rsp_valid_q;
	cpa_pkg::rsp_word_t rsp_q;

	// output register is free when empty or being drained this cycle
	assign out_free = !rsp_valid_q || !rsp_stall;

	cpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (req.action),
		.out_free  (out_free),
		.stat      (stat),
		.req_stall (req_stall),
		.load_out  (load_out),
		.cmd       (cmd)
	);

	cpa_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload held while stalled: loaded only when out_free
	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== design/cpa_checker.sv =====
// ----------------------------------------------------------------------------
// cpa_checker: port-level checks for the cell pool allocator
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_stall,
	input wire cpa_pkg::req_word_t req,
	input wire logic               rsp_valid,
	input wire logic               rsp_stall,
	input wire cpa_pkg::rsp_word_t rsp
);

	// one action at a time: a taken request blocks the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while an action was in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response word changed");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= cpa_pkg::ST_OVERFLOW)
		else $error("status code out of range");

	a_fail_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != cpa_pkg::ST_OK |-> rsp.result_cell == '0)
		else $error("failed action returned a cell");

	a_freed_sweep_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.freed_cells != '0 |->
			rsp.status == cpa_pkg::ST_OK && rsp.result_cell == '0)
		else $error("freed count on a non-sweep word");

endmodule

bind cell_pool_alloc_mark_sweep cpa_checker u_cpa_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cell pool allocator with mark and sweep
// Drives alloc, free, mark and sweep words with random idling on both sides
// and checks every response against a cycle-free model of pool, stack and
// rover kept inside a small scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpa_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RANDOM_WORDS  = 680;
	localparam int LONG_HOLD     = 400;   // receiver hold-off, well past the block's buffering
	localparam int SETTLE_CYCLES = 300;   // longer than a full-pool scan or sweep
	// ~700 words end to end; each worst case is a full idle gap and a full stall
	// around a full-pool scan, so this is several times the slowest correct run
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int LIVE_KEEP     = 256;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks pool, free stack and rover, and holds the responses
	// still owed by the block, oldest first.
	// ------------------------------------------------------------------------
	class pool_tracker;
		logic [1:0]       cell_state [POOL_CELLS];   // bit 0 in use, bit 1 marked
		logic [IDX_W-1:0] recycled [POOL_CELLS];     // LIFO of freed cell numbers
		int unsigned      stack_top;
		int unsigned      rover_blk;
		int unsigned      rover_pos;
		int unsigned      in_use;
		rsp_word_t        awaited [$];
		logic [IDX_W-1:0] live_cells [$];            // recent alloc results, for marking
		int unsigned      errors;
		int unsigned      checked;
		int unsigned      action_count [4];
		int unsigned      status_count [5];

		function new();
			foreach (cell_state[i]) cell_state[i] = 2'b00;
			stack_top = 0;
			rover_blk = 0;
			rover_pos = 0;
			in_use    = 0;
			errors    = 0;
			checked   = 0;
			foreach (action_count[i]) action_count[i] = 0;
			foreach (status_count[i]) status_count[i] = 0;
		endfunction

		// first free cell of block blk at or after position start
		function bit claim_from(int unsigned blk, int unsigned start,
				output logic [IDX_W-1:0] got);
			int unsigned flat;
			got = '0;
			for (int unsigned c = start; c < CELLS_PER_BLOCK; c++) begin
				flat = blk * CELLS_PER_BLOCK + c;
				if (cell_state[flat] == 2'b00) begin
					cell_state[flat] = 2'b01;
					in_use++;
					rover_blk = blk;
					rover_pos = c + 1;
					got = IDX_W'(flat);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// next fit: tail of the rover block, then whole blocks round the ring
		function bit scan_for_free(output logic [IDX_W-1:0] got);
			int unsigned blk;
			if (rover_blk >= NUM_BLOCKS) rover_blk = 0;
			if (claim_from(rover_blk, rover_pos, got)) return 1'b1;
			rover_pos = 0;
			blk = rover_blk;
			do begin
				if (claim_from(blk, 0, got)) return 1'b1;
				blk = (blk + 1) % NUM_BLOCKS;
			end while (blk != rover_blk);
			return 1'b0;
		endfunction

		function rsp_word_t apply_action(req_word_t w);
			rsp_word_t        r;
			logic [IDX_W-1:0] got;
			int unsigned      swept;
			r = '0;
			r.status = ST_OK;
			swept = 0;
			case (w.action)
				ACT_ALLOC: begin
					if (stack_top > 0) begin
						// popped cell goes out as is, map and count untouched
						stack_top--;
						r.result_cell = recycled[stack_top];
					end else if (scan_for_free(got)) begin
						r.result_cell = got;
					end else begin
						r.status = ST_NOFREE;
					end
					if (r.status == ST_OK) begin
						live_cells.push_back(r.result_cell);
						if (live_cells.size() > LIVE_KEEP) void'(live_cells.pop_front());
					end
				end
				ACT_FREE: begin
					if (stack_top >= POOL_CELLS) begin
						r.status = ST_OVERFLOW;
					end else begin
						recycled[stack_top] = w.cell_index;
						stack_top++;
					end
				end
				ACT_MARK: begin
					if (cell_state[w.cell_index][1]) r.status = ST_MARKED;
					else if (!cell_state[w.cell_index][0]) r.status = ST_NOTALLOC;
					else cell_state[w.cell_index][1] = 1'b1;
				end
				default: begin
					// sweep: stack entries are left alone even when their cell is freed
					in_use = 0;
					foreach (cell_state[i]) begin
						if (cell_state[i][1]) begin
							in_use++;
							cell_state[i] = 2'b01;
						end else if (cell_state[i][0]) begin
							swept++;
							cell_state[i] = 2'b00;
						end
					end
				end
			endcase
			r.used_cells  = CNT_W'(in_use);
			r.freed_cells = CNT_W'(swept);
			return r;
		endfunction

		function void note_request(req_word_t w);
			rsp_word_t r;
			r = apply_action(w);
			action_count[w.action]++;
			status_count[r.status]++;
			awaited.push_back(r);
		endfunction

		function void compare_field(string field, logic [CNT_W-1:0] want,
				logic [CNT_W-1:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0d, got %0d", field, want, seen);
				errors++;
			end
		endfunction

		function void check_response(rsp_word_t seen);
			rsp_word_t want;
			if (awaited.size() == 0) begin
				$error("response word with nothing awaited");
				errors++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			compare_field("status", CNT_W'(want.status), CNT_W'(seen.status));
			compare_field("result_cell", CNT_W'(want.result_cell), CNT_W'(seen.result_cell));
			compare_field("used_cells", want.used_cells, seen.used_cells);
			compare_field("freed_cells", want.freed_cells, seen.freed_cells);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the block
	// ------------------------------------------------------------------------
	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	pool_tracker tracker = new();

	bit          hold_off_pending = 1'b0;   // asks the receiver for one long hold-off
	bit          send_quiet = 1'b0;         // stretch of back-to-back sending
	int unsigned send_left_in_mode = 0;
	int unsigned cycle_count = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	cell_pool_alloc_mark_sweep DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// watchdog: a hang anywhere ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Offers one word after a random idle gap and returns on the edge that
	// takes it. Idle gaps come in modes: mostly random lengths, sometimes a run
	// of 40 words with none, so the block also sees back-to-back requests.
	task automatic send_word(input logic [1:0] act, input logic [IDX_W-1:0] idx);
		req_word_t   w;
		int unsigned gap;
		w.action     = act;
		w.cell_index = idx;
		if (send_left_in_mode == 0) begin
			send_quiet = ($urandom_range(0, 3) == 0);
			send_left_in_mode = 40;
		end
		send_left_in_mode--;
		gap = send_quiet ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall !== 1'b0);
		tracker.note_request(w);
	endtask

	// Drop valid and hold until every owed response has been taken.
	// Always advances at least one edge so valid is never driven twice in a step.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (tracker.awaited.size() != 0) @(posedge clk);
	endtask

	// A recently handed-out cell with chance pct_live percent, otherwise anywhere in the pool.
	function automatic logic [IDX_W-1:0] pick_target(int unsigned pct_live);
		if (tracker.live_cells.size() != 0 && $urandom_range(0, 99) < pct_live)
			return tracker.live_cells[$urandom_range(0, tracker.live_cells.size() - 1)];
		return IDX_W'($urandom_range(0, POOL_CELLS - 1));
	endfunction

	// ------------------------------------------------------------------------
	// Receiver side: draws a stall per word, and takes the long hold-off when
	// asked. Stall is also raised while nothing is valid, so it lands on every
	// phase of a scan or sweep.
	// ------------------------------------------------------------------------
	initial begin : rsp_side
		int unsigned stall_left;
		int unsigned words_in_mode;
		bit          quiet;
		stall_left    = 0;
		words_in_mode = 0;
		quiet         = 1'b0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				tracker.check_response(rsp);
				if (words_in_mode == 0) begin
					quiet = ($urandom_range(0, 3) == 0);
					words_in_mode = 40;
				end
				words_in_mode--;
				stall_left = quiet ? 0 : $urandom_range(0, 16);
			end
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left != 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned pick;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// -- directed: every action, both ends of the index, the odd corners
		send_word(ACT_ALLOC, '0);            // empty stack: scan from reset gives cell 0
		send_word(ACT_ALLOC, '1);            // index is ignored by alloc; cell 1
		send_word(ACT_MARK, '0);             // newly marked
		send_word(ACT_MARK, '0);             // already marked
		send_word(ACT_MARK, '1);             // last cell, never handed out
		send_word(ACT_FREE, '1);             // push is blind to the map
		send_word(ACT_ALLOC, '0);            // pop: last cell back, count unchanged
		send_word(ACT_FREE, IDX_W'(1));      // in-use, unmarked cell onto the stack
		send_word(ACT_SWEEP, '1);            // cell 1 freed in map, its stack entry stays
		send_word(ACT_ALLOC, '0);            // pops cell 1 though the map says free
		send_word(ACT_ALLOC, '0);            // scan resumes at the rover
		send_word(ACT_MARK, IDX_W'(1));      // not in use per the map
		send_word(ACT_FREE, IDX_W'(2));
		send_word(ACT_FREE, IDX_W'(2));      // same cell pushed twice
		send_word(ACT_SWEEP, '0);            // nothing marked: everything goes
		send_word(ACT_ALLOC, '0);
		send_word(ACT_ALLOC, '0);
		wait_drained();

		// -- random: alloc/mark/sweep rounds with some frees and noise.
		// The long receiver hold-off lands at the start while words keep coming.
		hold_off_pending = 1'b1;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_word(ACT_ALLOC, IDX_W'($urandom));
			else if (pick < 70)
				send_word(ACT_MARK, pick_target(80));
			else if (pick < 85)
				send_word(ACT_FREE, pick_target(50));
			else if (pick < 89)
				send_word(ACT_SWEEP, IDX_W'($urandom));
			else
				send_word(2'($urandom_range(0, 3)), IDX_W'($urandom));
			if ($urandom_range(0, 49) == 0)
				wait_drained();
		end

		// -- wind down: everything owed, then a quiet spell for strays
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.awaited.size() != 0) begin
			$error("%0d responses never arrived", tracker.awaited.size());
			tracker.errors++;
		end

		$display("Covered %0d words: alloc %0d, free %0d, mark %0d, sweep %0d",
			tracker.checked, tracker.action_count[ACT_ALLOC],
			tracker.action_count[ACT_FREE], tracker.action_count[ACT_MARK],
			tracker.action_count[ACT_SWEEP]);
		$display("Outcomes: ok %0d, pool full %0d, marked twice %0d, not in use %0d, stack full %0d",
			tracker.status_count[ST_OK], tracker.status_count[ST_NOFREE],
			tracker.status_count[ST_MARKED], tracker.status_count[ST_NOTALLOC],
			tracker.status_count[ST_OVERFLOW]);
		if (tracker.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
